// ----- hw/rtl/blr_pkg.sv -----
// Shared types and codes for the line rasterizer.
package blr_pkg;

   // request kinds carried on req_tuser
   localparam logic MODE_START   = 1'b0;
   localparam logic MODE_ADVANCE = 1'b1;

   // command flags passed from the front end to the back end
   typedef struct packed {
      logic is_start;   // load a new segment
      logic is_empty;   // zero-length segment: go idle
      logic x_major;    // x is the axis that steps on every pixel
      logic neg_x;      // x steps downward
      logic neg_y;      // y steps downward
   } cmd_flags_type;

   localparam int CMD_FLAGS_W = $bits(cmd_flags_type);

endpackage

// ----- hw/rtl/blr_queue.sv -----
// Small command queue between the front end and the back end.
module blr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hw/rtl/blr_front.sv -----
// Front end: takes requests, classifies the segment and builds a back-end command.
module blr_front #(
   parameter int COORD_BITS = 10
) (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   mode,
   input  logic [COORD_BITS-1:0]  start_x,
   input  logic [COORD_BITS-1:0]  start_y,
   input  logic [COORD_BITS-1:0]  end_x,
   input  logic [COORD_BITS-1:0]  end_y,
   input  logic                   queue_full,
   output logic                   push,
   output blr_pkg::cmd_flags_type cmd_flags,
   output logic [COORD_BITS-1:0]  cmd_x,
   output logic [COORD_BITS-1:0]  cmd_y,
   output logic [COORD_BITS-1:0]  cmd_major,
   output logic [COORD_BITS-1:0]  cmd_minor
);

   logic [COORD_BITS:0]   dx, dy;
   logic [COORD_BITS:0]   dx_neg, dy_neg;
   logic [COORD_BITS-1:0] abs_x, abs_y;
   logic                  x_major;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      dx      = {1'b0, end_x} - {1'b0, start_x};
      dy      = {1'b0, end_y} - {1'b0, start_y};
      dx_neg  = -dx;
      dy_neg  = -dy;
      abs_x   = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
      abs_y   = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
      // ties on |dx| == |dy| go to the x-major octants; vertical lines fall out as y-major
      x_major = (abs_x >= abs_y);

      cmd_flags.is_start = (mode == blr_pkg::MODE_START);
      cmd_flags.is_empty = (dx == '0) && (dy == '0);
      cmd_flags.x_major  = x_major;
      cmd_flags.neg_x    = dx[COORD_BITS];
      cmd_flags.neg_y    = dy[COORD_BITS];

      cmd_x     = start_x;
      cmd_y     = start_y;
      cmd_major = x_major ? abs_x : abs_y;
      cmd_minor = x_major ? abs_y : abs_x;
   end

endmodule

// ----- hw/rtl/blr_back.sv -----
// Back end: holds the running segment and steps one pixel per advance command.
module blr_back #(
   parameter int COORD_BITS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   pop,
   input  blr_pkg::cmd_flags_type cmd_flags,
   input  logic [COORD_BITS-1:0]  cmd_x,
   input  logic [COORD_BITS-1:0]  cmd_y,
   input  logic [COORD_BITS-1:0]  cmd_major,
   input  logic [COORD_BITS-1:0]  cmd_minor,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [COORD_BITS-1:0]  pixel_x,
   output logic [COORD_BITS-1:0]  pixel_y,
   output logic                   last_pixel
);

   localparam int DEC_W = COORD_BITS + 3;

   blr_pkg::cmd_flags_type dir_ff, dir_in;
   logic                   active_ff, active_in;
   logic                   out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]  px_ff, px_in;
   logic [COORD_BITS-1:0]  py_ff, py_in;
   logic [COORD_BITS-1:0]  remain_ff, remain_in;
   logic [DEC_W-1:0]       decision_ff, decision_in;
   logic [DEC_W-1:0]       major2_ff, major2_in;
   logic [DEC_W-1:0]       minor2_ff, minor2_in;
   logic [COORD_BITS-1:0]  out_x_ff, out_x_in;
   logic [COORD_BITS-1:0]  out_y_ff, out_y_in;
   logic                   out_last_ff, out_last_in;

   logic                   emit;
   logic                   last_now;
   logic                   minor_step;
   logic                   x_step, y_step;

   // output register may take a new pixel when empty or being drained
   assign pop        = cmd_valid && (!out_valid_ff || rsp_tready);
   assign emit       = pop && !cmd_flags.is_start && active_ff;
   assign last_now   = (remain_ff == COORD_BITS'(1));
   assign minor_step = !decision_ff[DEC_W-1];
   assign x_step     = dir_ff.x_major || minor_step;
   assign y_step     = !dir_ff.x_major || minor_step;

   assign rsp_tvalid = out_valid_ff;
   assign pixel_x    = out_x_ff;
   assign pixel_y    = out_y_ff;
   assign last_pixel = out_last_ff;

   always_comb begin
      dir_in       = dir_ff;
      active_in    = active_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      remain_in    = remain_ff;
      decision_in  = decision_ff;
      major2_in    = major2_ff;
      minor2_in    = minor2_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;

      if (pop && cmd_flags.is_start) begin
         dir_in      = cmd_flags;
         active_in   = !cmd_flags.is_empty;
         px_in       = cmd_x;
         py_in       = cmd_y;
         remain_in   = cmd_major;
         major2_in   = {2'b00, cmd_major, 1'b0};
         minor2_in   = {2'b00, cmd_minor, 1'b0};
         decision_in = {2'b00, cmd_minor, 1'b0} - {3'b000, cmd_major};
      end else if (emit) begin
         out_valid_in = 1'b1;
         out_x_in     = px_ff;
         out_y_in     = py_ff;
         out_last_in  = last_now;
         if (x_step) begin
            px_in = dir_ff.neg_x ? px_ff - 1'b1 : px_ff + 1'b1;
         end
         if (y_step) begin
            py_in = dir_ff.neg_y ? py_ff - 1'b1 : py_ff + 1'b1;
         end
         decision_in = decision_ff + minor2_ff - (minor_step ? major2_ff : '0);
         remain_in   = remain_ff - 1'b1;
         if (last_now) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      remain_ff   <= remain_in;
      decision_ff <= decision_in;
      major2_ff   <= major2_in;
      minor2_ff   <= minor2_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

endmodule

// ----- hw/rtl/bresenham_line_rasterizer.sv -----
// Top level of the eight-octant line rasterizer.
//
//   channel  direction  tdata                               tuser  tlast
//   req_     in         start_x, start_y, end_x, end_y      mode   -
//   rsp_     out        pixel_x, pixel_y                    -      last_pixel
//
// One request per clock, sustained while rsp_ accepts pixels; each advance request's
// pixel passes through the command queue, then the output register.
// The per-pixel rate is set by the back end's decision update.
// Synchronous reset clears the queue, the running segment and the output register.
// A stalled rsp_ side fills the two-entry command queue, then drops req_tready.
module bresenham_line_rasterizer #(
   parameter int COORD_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // start_x, start_y, end_x, end_y (low to high), zero padded
   input  logic [((4*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   // mode
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // pixel_x, pixel_y (low to high), zero padded
   output logic [((2*COORD_BITS+7)/8)*8-1:0]     rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int RSP_W = ((2*COORD_BITS+7)/8)*8;
   localparam int CMD_W = blr_pkg::CMD_FLAGS_W + 4*COORD_BITS;

   blr_pkg::cmd_flags_type front_flags, back_flags;
   logic [COORD_BITS-1:0]  front_x, front_y, front_major, front_minor;
   logic [COORD_BITS-1:0]  back_x, back_y, back_major, back_minor;
   logic [CMD_W-1:0]       q_wr_data, q_rd_data;
   logic                   push, pop, q_full, q_not_empty;
   logic [COORD_BITS-1:0]  pixel_x, pixel_y;

   blr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .mode       (req_tuser),
      .start_x    (req_tdata[COORD_BITS-1:0]),
      .start_y    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .end_x      (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .end_y      (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .queue_full (q_full),
      .push       (push),
      .cmd_flags  (front_flags),
      .cmd_x      (front_x),
      .cmd_y      (front_y),
      .cmd_major  (front_major),
      .cmd_minor  (front_minor)
   );

   assign q_wr_data = {front_flags, front_x, front_y, front_major, front_minor};
   assign {back_flags, back_x, back_y, back_major, back_minor} = q_rd_data;

   blr_queue #(.WIDTH(CMD_W), .DEPTH(2)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_data   (q_wr_data),
      .pop       (pop),
      .rd_data   (q_rd_data),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   blr_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_not_empty),
      .pop        (pop),
      .cmd_flags  (back_flags),
      .cmd_x      (back_x),
      .cmd_y      (back_y),
      .cmd_major  (back_major),
      .cmd_minor  (back_minor),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .pixel_x    (pixel_x),
      .pixel_y    (pixel_y),
      .last_pixel (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({pixel_y, pixel_x});

endmodule
